FILE: sv/crlf_lrq_pkg.sv
package crlf_lrq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int LINE_BYTES  = 64;

	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int BYTE_W    = $clog2(LINE_BYTES);
	localparam int POS_W     = $clog2(LINE_BYTES + 1);
	localparam int LEN_W     = $clog2(LINE_BYTES - 1);
	localparam int ADDR_W    = PTR_W + BYTE_W;
	localparam int MEM_DEPTH = QUEUE_DEPTH * (1 << BYTE_W);

	// fixed field widths
	localparam int REQ_W  = 2;
	localparam int DATA_W = 8;
	localparam int IDX_W  = 6;
	localparam int HLEN_W = 6;

	localparam logic [DATA_W-1:0] CHAR_CR = 8'h0D;
	localparam logic [DATA_W-1:0] CHAR_LF = 8'h0A;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH    = 2'd0,
		REQ_READ    = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_NONE    = 2'd3
	} req_e_t;

	typedef enum logic {
		ST_IDLE,
		ST_RESP
	} state_e_t;

	typedef struct packed {
		logic exec;  // apply the accepted transaction to the queue state
		logic load;  // move the result into the output register
	} lrq_cmd_t;

endpackage

FILE: sv/crlf_lrq_ctrl.sv
module crlf_lrq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output crlf_lrq_pkg::lrq_cmd_t cmd
);
	import crlf_lrq_pkg::*;

	state_e_t state_q;
	state_e_t state_d;
	logic     out_valid_q;
	logic     slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.exec = in_valid;
			end
			ST_RESP: begin
				cmd.load = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/crlf_lrq_dp.sv
module crlf_lrq_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  crlf_lrq_pkg::lrq_cmd_t              cmd,
	input  logic [crlf_lrq_pkg::REQ_W-1:0]      req_type,
	input  logic [crlf_lrq_pkg::DATA_W-1:0]     rx_byte,
	input  logic [crlf_lrq_pkg::IDX_W-1:0]      read_index,
	output logic [crlf_lrq_pkg::DATA_W-1:0]     read_byte,
	output logic [crlf_lrq_pkg::HLEN_W-1:0]     head_length,
	output logic                                is_empty,
	output logic                                is_full,
	output logic                                line_committed,
	output logic                                line_dropped,
	output logic                                byte_dropped
);
	import crlf_lrq_pkg::*;

	// line memory and per-entry lengths: no reset, contents valid once written
	logic [DATA_W-1:0] mem_q [MEM_DEPTH];
	logic [LEN_W-1:0]  len_q [QUEUE_DEPTH];
	logic [DATA_W-1:0] rdata_q;

	logic [PTR_W-1:0]  head_q, head_d;
	logic [PTR_W-1:0]  tail_q, tail_d;
	logic [CNT_W-1:0]  used_q, used_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [DATA_W-1:0] prev_q, prev_d;

	logic rd_ok_q, rd_ok_d;
	logic commit_q, commit_d;
	logic ldrop_q, ldrop_d;
	logic bdrop_q, bdrop_d;

	req_e_t            req;
	logic              full_now;
	logic              at_cap;
	logic              term;
	logic [POS_W-1:0]  count;
	logic [LEN_W-1:0]  new_len;
	logic              len_we;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;

	assign req      = req_e_t'(req_type);
	assign full_now = (used_q == CNT_W'(QUEUE_DEPTH));
	assign at_cap   = (pos_q == POS_W'(LINE_BYTES));
	assign count    = at_cap ? pos_q : pos_q + POS_W'(1);
	assign term     = (prev_q == CHAR_CR) && (rx_byte == CHAR_LF);
	assign new_len  = (count >= POS_W'(2)) ? LEN_W'(count - POS_W'(2)) : '0;
	assign waddr    = {tail_q, pos_q[BYTE_W-1:0]};
	assign raddr    = {head_q, BYTE_W'(read_index)};
	assign mem_we   = cmd.exec && (req == REQ_PUSH) && !at_cap && !full_now;
	assign mem_re   = cmd.exec && (req == REQ_READ);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		used_d   = used_q;
		pos_d    = pos_q;
		prev_d   = prev_q;
		rd_ok_d  = 1'b0;
		commit_d = 1'b0;
		ldrop_d  = 1'b0;
		bdrop_d  = 1'b0;
		len_we   = 1'b0;
		if (cmd.exec) begin
			unique case (req)
				REQ_PUSH: begin
					bdrop_d = at_cap;
					pos_d   = count;
					if (term) begin
						if (full_now) begin
							ldrop_d = 1'b1;
						end else begin
							len_we   = 1'b1;
							tail_d   = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
								: tail_q + PTR_W'(1);
							used_d   = used_q + CNT_W'(1);
							commit_d = 1'b1;
						end
						pos_d  = '0;
						prev_d = '0;
					end else begin
						prev_d = rx_byte;
					end
				end
				REQ_READ: begin
					rd_ok_d = (used_q != '0) && (read_index < len_q[head_q]);
				end
				REQ_RELEASE: begin
					if (used_q != '0) begin
						head_d = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
							: head_q + PTR_W'(1);
						used_d = used_q - CNT_W'(1);
					end
				end
				REQ_NONE: begin
					rd_ok_d = 1'b0;
				end
				default: rd_ok_d = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
			pos_q  <= '0;
			prev_q <= '0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			used_q <= used_d;
			pos_q  <= pos_d;
			prev_q <= prev_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= rx_byte;
		end
		if (mem_re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_q[tail_q] <= new_len;
		end
		if (cmd.exec) begin
			rd_ok_q  <= rd_ok_d;
			commit_q <= commit_d;
			ldrop_q  <= ldrop_d;
			bdrop_q  <= bdrop_d;
		end
	end

	// result register, built from the state left by the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			read_byte      <= rd_ok_q ? rdata_q : '0;
			head_length    <= (used_q != '0) ? HLEN_W'(len_q[head_q]) : '0;
			is_empty       <= (used_q == '0);
			is_full        <= (used_q == CNT_W'(QUEUE_DEPTH));
			line_committed <= commit_q;
			line_dropped   <= ldrop_q;
			byte_dropped   <= bdrop_q;
		end
	end

endmodule

FILE: sv/crlf_line_ring_queue_core.sv
// The input transaction updates the queue state and the registered read port of
// the line memory; the result register then loads once the output slot is free.
// No new transaction is accepted until the result register has loaded.
// A stalled result holds off the next input. Reset (arst_n, async, active low):
// pointers, fill count and line state clear; line memory and lengths do not.
module crlf_line_ring_queue_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [crlf_lrq_pkg::REQ_W-1:0]      req_type,
	input  logic [crlf_lrq_pkg::DATA_W-1:0]     rx_byte,
	input  logic [crlf_lrq_pkg::IDX_W-1:0]      read_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [crlf_lrq_pkg::DATA_W-1:0]     read_byte,
	output logic [crlf_lrq_pkg::HLEN_W-1:0]     head_length,
	output logic                                is_empty,
	output logic                                is_full,
	output logic                                line_committed,
	output logic                                line_dropped,
	output logic                                byte_dropped
);
	import crlf_lrq_pkg::*;

	lrq_cmd_t cmd;

	crlf_lrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	crlf_lrq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.req_type       (req_type),
		.rx_byte        (rx_byte),
		.read_index     (read_index),
		.read_byte      (read_byte),
		.head_length    (head_length),
		.is_empty       (is_empty),
		.is_full        (is_full),
		.line_committed (line_committed),
		.line_dropped   (line_dropped),
		.byte_dropped   (byte_dropped)
	);

endmodule

FILE: sv/crlf_lrq_chk.sv
module crlf_lrq_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [crlf_lrq_pkg::DATA_W-1:0]     read_byte,
	input logic [crlf_lrq_pkg::HLEN_W-1:0]     head_length,
	input logic                                is_empty,
	input logic                                is_full,
	input logic                                line_committed,
	input logic                                line_dropped
);
	import crlf_lrq_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_byte)
			&& $stable(head_length) && $stable(is_empty))
		else $error("result changed while stalled");

	// one transaction in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a transaction while busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_empty && is_full) && !(line_committed && line_dropped))
		else $error("inconsistent queue status");

	// an empty queue reports no head line and no read data
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> head_length == '0 && read_byte == '0
			&& !line_dropped)
		else $error("empty queue reported data");

endmodule

bind crlf_line_ring_queue_core crlf_lrq_chk u_chk (.*);

FILE: bench/tb_crlf_line_ring_queue_core.sv
module tb_crlf_line_ring_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	import crlf_lrq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AFTER  = 200;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		req_e_t            req;
		logic [DATA_W-1:0] rx;
		logic [IDX_W-1:0]  idx;
	} line_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] rbyte;
		logic [HLEN_W-1:0] hlen;
		logic              empty;
		logic              full;
		logic              committed;
		logic              ldrop;
		logic              bdrop;
	} queue_status_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [REQ_W-1:0]    req_type = REQ_NONE;
	logic [DATA_W-1:0]   rx_byte = '0;
	logic [IDX_W-1:0]    read_index = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [DATA_W-1:0]   read_byte;
	logic [HLEN_W-1:0]   head_length;
	logic                is_empty;
	logic                is_full;
	logic                line_committed;
	logic                line_dropped;
	logic                byte_dropped;

	crlf_line_ring_queue_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.rx_byte        (rx_byte),
		.read_index     (read_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_byte      (read_byte),
		.head_length    (head_length),
		.is_empty       (is_empty),
		.is_full        (is_full),
		.line_committed (line_committed),
		.line_dropped   (line_dropped),
		.byte_dropped   (byte_dropped)
	);

	initial forever #10 clk = ~clk;

	line_req_t     req_backlog_q[$];
	queue_status_t status_due_q[$];
	int            mismatch_cnt = 0;

	// shadow of the line queue
	logic [DATA_W-1:0] line_mem [QUEUE_DEPTH*LINE_BYTES];
	bit                byte_written [QUEUE_DEPTH*LINE_BYTES];
	logic [HLEN_W-1:0] len_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]  head_ptr = '0;
	logic [PTR_W-1:0]  tail_ptr = '0;
	int                used_cnt = 0;
	int                line_pos = 0;
	logic [DATA_W-1:0] prev_rx = '0;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	task automatic advance_line_queue(input line_req_t it, output queue_status_t st);
		bit was_full;
		int count;
		int slot;
		st = '0;
		was_full = (used_cnt >= QUEUE_DEPTH);
		case (it.req)
			REQ_PUSH: begin
				if (line_pos >= LINE_BYTES) begin
					st.bdrop = 1'b1;
					count = LINE_BYTES;
				end else begin
					if (!was_full) begin
						slot = int'(tail_ptr) * LINE_BYTES + line_pos;
						line_mem[slot] = it.rx;
						byte_written[slot] = 1'b1;
					end
					line_pos++;
					count = line_pos;
				end
				if (prev_rx == CHAR_CR && it.rx == CHAR_LF) begin
					if (was_full) begin
						st.ldrop = 1'b1;
					end else begin
						len_mem[tail_ptr] = (count >= 2) ? HLEN_W'(count - 2) : '0;
						tail_ptr = ring_next(tail_ptr);
						used_cnt++;
						st.committed = 1'b1;
					end
					line_pos = 0;
					prev_rx = '0;
				end else begin
					prev_rx = it.rx;
				end
			end
			REQ_READ: begin
				if (used_cnt != 0 && it.idx < len_mem[head_ptr])
					st.rbyte = line_mem[int'(head_ptr) * LINE_BYTES + int'(it.idx)];
			end
			REQ_RELEASE: begin
				if (used_cnt != 0) begin
					head_ptr = ring_next(head_ptr);
					used_cnt--;
				end
			end
			default: ;
		endcase
		if (used_cnt != 0)
			st.hlen = len_mem[head_ptr];
		st.empty = (used_cnt == 0);
		st.full = (used_cnt >= QUEUE_DEPTH);
	endtask

	// a position skipped while the queue was full holds nothing defined; aim past the line
	function automatic line_req_t steer_clear_of_unwritten(input line_req_t it);
		line_req_t o;
		o = it;
		if (it.req == REQ_READ && used_cnt != 0 && it.idx < len_mem[head_ptr] &&
				!byte_written[int'(head_ptr) * LINE_BYTES + int'(it.idx)])
			o.idx = '1;
		return o;
	endfunction

	// sender
	line_req_t offered;
	queue_status_t predicted;
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_NONE;
			rx_byte <= '0;
			read_index <= '0;
		end else begin
			if (in_valid && in_ready) begin
				advance_line_queue(offered, predicted);
				status_due_q.push_back(predicted);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (req_backlog_q.size() > 0) begin
					offered = steer_clear_of_unwritten(req_backlog_q.pop_front());
					req_type <= offered.req;
					rx_byte <= offered.rx;
					read_index <= offered.idx;
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
							: $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// four-state compare so an unknown output never passes as zero
	task automatic check_field(input string name, input logic [31:0] due,
			input logic [31:0] got);
		if (due !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, due, got);
			mismatch_cnt++;
		end
	endtask

	// receiver
	queue_status_t due;
	int results_seen = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit ready_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (status_due_q.size() == 0) begin
					$display("%0t: result transaction with nothing outstanding", $time);
					mismatch_cnt++;
				end else begin
					due = status_due_q.pop_front();
					check_field("read_byte", due.rbyte, read_byte);
					check_field("head_length", due.hlen, head_length);
					check_field("is_empty", due.empty, is_empty);
					check_field("is_full", due.full, is_full);
					check_field("line_committed", due.committed, line_committed);
					check_field("line_dropped", due.ldrop, line_dropped);
					check_field("byte_dropped", due.bdrop, byte_dropped);
				end
			end
			// one long hold-off so the core backs up into its input
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
				if ($urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 8);
			end
			out_ready <= ready_next;
		end
	end

	int cycle_cnt = 0;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic add_req(input req_e_t req, input int rx, input int idx);
		line_req_t it;
		it.req = req;
		it.rx = DATA_W'(rx);
		it.idx = IDX_W'(idx);
		req_backlog_q.push_back(it);
	endtask

	task automatic add_bytes(input int n);
		for (int i = 0; i < n; i++)
			add_req(REQ_PUSH, $urandom_range(0, 255), $urandom_range(0, 63));
	endtask

	task automatic add_line(input int n);
		add_bytes(n);
		add_req(REQ_PUSH, CHAR_CR, $urandom_range(0, 63));
		add_req(REQ_PUSH, CHAR_LF, $urandom_range(0, 63));
	endtask

	function automatic int pick_line_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 16)
			return $urandom_range(0, 8);
		else if (r < 19)
			return $urandom_range(9, 40);
		return $urandom_range(60, 70);
	endfunction

	function automatic int pick_index();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 9);
	endfunction

	int pick;

	initial begin
		// directed: empty queue, terminator corners, field extremes
		add_req(REQ_READ, 0, 0);
		add_req(REQ_RELEASE, 0, 0);
		add_req(REQ_NONE, 0, 0);
		add_req(REQ_PUSH, CHAR_LF, 0);
		add_req(REQ_PUSH, CHAR_CR, 0);
		add_req(REQ_PUSH, CHAR_LF, 63);
		add_req(REQ_PUSH, CHAR_CR, 0);
		add_req(REQ_PUSH, CHAR_LF, 0);
		add_req(REQ_PUSH, 255, 63);
		add_req(REQ_PUSH, 0, 0);
		add_req(REQ_PUSH, CHAR_CR, 0);
		add_req(REQ_PUSH, CHAR_CR, 0);
		add_req(REQ_PUSH, CHAR_LF, 0);
		add_req(REQ_READ, 255, 0);
		add_req(REQ_READ, 0, 63);
		add_req(REQ_RELEASE, 0, 0);
		add_req(REQ_READ, 0, 0);
		add_req(REQ_RELEASE, 0, 0);
		add_req(REQ_READ, 0, 2);
		add_req(REQ_READ, 0, 1);
		add_req(REQ_NONE, 255, 63);
		add_req(REQ_RELEASE, 0, 0);
		add_req(REQ_RELEASE, 0, 0);

		// overlong line, then fill past capacity
		add_line(70);
		add_req(REQ_READ, 0, 61);
		for (int i = 0; i < QUEUE_DEPTH + 2; i++)
			add_line($urandom_range(0, 3));

		while (req_backlog_q.size() < 740) begin
			pick = $urandom_range(0, 99);
			if (pick < 38) begin
				add_line(pick_line_len());
				repeat ($urandom_range(0, 3))
					add_req(REQ_READ, $urandom_range(0, 255), pick_index());
			end else if (pick < 55) begin
				repeat ($urandom_range(1, 4))
					add_req(REQ_READ, $urandom_range(0, 255), pick_index());
			end else if (pick < 77) begin
				repeat ($urandom_range(1, 3))
					add_req(REQ_RELEASE, $urandom_range(0, 255), $urandom_range(0, 63));
			end else if (pick < 85) begin
				// unterminated fragment; releases may land in the middle of a line
				add_bytes($urandom_range(1, 4));
				if ($urandom_range(0, 1) == 0)
					add_req(REQ_NONE, $urandom_range(0, 255), $urandom_range(0, 63));
			end else if (pick < 91) begin
				if ($urandom_range(0, 1) == 0) begin
					add_req(REQ_PUSH, CHAR_LF, 0);
				end else begin
					add_req(REQ_PUSH, CHAR_CR, 0);
					add_req(REQ_PUSH, $urandom_range(0, 255), 0);
					add_req(REQ_PUSH, CHAR_LF, 0);
				end
			end else if (pick < 96) begin
				repeat ($urandom_range(4, 10))
					add_line($urandom_range(0, 3));
			end else begin
				repeat (QUEUE_DEPTH)
					add_req(REQ_RELEASE, 0, 0);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog_q.size() != 0 || in_valid)
			@(posedge clk);
		while (status_due_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
